// File: hw/rtl/pntp_pkg.sv
// Shared types and constants for the prefixed number token parser.
// Used by every module of the block; depends on nothing.
package pntp_pkg;

  localparam int CELL_BITS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int BASE_BITS  = 5;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS  = 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CHAR_BITS-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_BITS-1:0] CH_HASH    = 8'h23;
  localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_BITS-1:0] CASE_SHIFT = 8'h20;

  localparam logic [BASE_BITS-1:0] BASE_MIN  = 5'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX  = 5'd16;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 5'd16;
  localparam logic [BASE_BITS-1:0] BASE_BIN  = 5'd2;
  localparam logic [DIGIT_BITS-1:0] HEX_TEN  = 4'd10;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } pntp_in_t;

  typedef struct packed {
    logic                          is_number;
    logic signed [VALUE_BITS-1:0]  value;
  } pntp_out_t;

  // One classified character handed from front to back.
  typedef struct packed {
    logic                  start;  // first character of a token
    logic                  neg;    // token began with '-'
    logic                  skip;   // prefix character, no digit
    logic                  bad;    // not a digit below the base
    logic [DIGIT_BITS-1:0] digit;
    logic [BASE_BITS-1:0]  base;
    logic                  last;
  } pntp_entry_t;

endpackage

// File: hw/rtl/prefixed_number_token_parser.sv
// Prefixed number token parser: one character per item, one result per token.
// The last character reaches the result via the queue register, then the output register.
// Throughput: one item per cycle unless in_stall; the back end's one multiplier sets it.
// Reset: synchronous, active low; default base returns to 10, the queue empties,
// and the parser waits for the first character of a new token.
// Depends on pntp_pkg, pntp_front, pntp_queue and pntp_back.
module prefixed_number_token_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  // character items
  input  logic                  in_valid,
  input  pntp_pkg::pntp_in_t    in_item,
  output logic                  in_stall,
  // result items
  output logic                  out_valid,
  output pntp_pkg::pntp_out_t   out_item,
  input  logic                  out_stall,
  // default base register
  input  logic                  cfg_valid,
  input  logic [4:0]            cfg_data,
  output logic                  cfg_ready
);
  import pntp_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  pntp_entry_t q_wdata;
  pntp_entry_t q_rdata;

  // Classify each character; pick the token base on its first character.
  pntp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Decouple the two sides so a stalled result does not block input until the queue fills.
  pntp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Accumulate digits, apply sign, present the result.
  pntp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // A failed token always reports zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_number || out_item.value == '0))
    else $error("failed token with nonzero value");

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  // Never retire a final character while the result register is held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.last) |-> !(out_valid && out_stall))
    else $error("stalled result overwritten");

  // A popped final character shows up as a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.last) |=> out_valid)
    else $error("result lost");

endmodule

// File: hw/rtl/pntp_front.sv
// Front end: accepts characters, owns the default base register,
// tracks token start and base, classifies each character. Uses pntp_pkg.
module pntp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  pntp_pkg::pntp_in_t       in_item,
  output logic                     in_stall,
  input  logic                     cfg_valid,
  input  logic [4:0]               cfg_data,
  output logic                     cfg_ready,
  input  logic                     q_full,
  output logic                     q_push,
  output pntp_pkg::pntp_entry_t    q_wdata
);
  import pntp_pkg::*;

  logic [BASE_BITS-1:0]  dflt_base_r, dflt_base_nxt;
  logic [BASE_BITS-1:0]  tok_base_r, tok_base_nxt;
  logic                  at_start_r, at_start_nxt;
  logic [BASE_BITS-1:0]  clamped;
  logic [BASE_BITS-1:0]  base_now;
  logic [CHAR_BITS-1:0]  c_low;
  logic [DIGIT_BITS-1:0] digit;
  logic                  hex_ok;
  logic                  is_prefix;
  logic                  is_minus;
  logic                  accept;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept;

  always_comb begin
    clamped = dflt_base_r;
    if (dflt_base_r < BASE_MIN) begin
      clamped = BASE_MIN;
    end else if (dflt_base_r > BASE_MAX) begin
      clamped = BASE_MAX;
    end
  end

  // Lower case, then map onto the hex digit set.
  always_comb begin
    c_low = in_item.char_code;
    if (in_item.char_code >= CH_UP_A && in_item.char_code <= CH_UP_Z) begin
      c_low = in_item.char_code + CASE_SHIFT;
    end
    hex_ok = 1'b0;
    digit  = '0;
    if (c_low >= CH_ZERO && c_low <= CH_NINE) begin
      hex_ok = 1'b1;
      digit  = DIGIT_BITS'(c_low - CH_ZERO);
    end else if (c_low >= CH_LOW_A && c_low <= CH_LOW_F) begin
      hex_ok = 1'b1;
      digit  = DIGIT_BITS'(c_low - CH_LOW_A) + HEX_TEN;
    end
  end

  always_comb begin
    is_prefix = 1'b0;
    is_minus  = 1'b0;
    base_now  = tok_base_r;
    if (at_start_r) begin
      base_now = clamped;
      priority if (in_item.char_code == CH_DOLLAR) begin
        base_now  = BASE_HEX;
        is_prefix = 1'b1;
      end else if (in_item.char_code == CH_PERCENT) begin
        base_now  = BASE_BIN;
        is_prefix = 1'b1;
      end else if (in_item.char_code == CH_HASH) begin
        base_now  = BASE_DEC;
        is_prefix = 1'b1;
      end else if (in_item.char_code == CH_MINUS) begin
        is_minus  = 1'b1;
        is_prefix = 1'b1;
      end else begin
      end
    end
  end

  always_comb begin
    q_wdata.start = at_start_r;
    q_wdata.neg   = is_minus;
    q_wdata.skip  = is_prefix;
    q_wdata.bad   = !hex_ok || ({1'b0, digit} >= base_now);
    q_wdata.digit = digit;
    q_wdata.base  = base_now;
    q_wdata.last  = in_item.last_char;
  end

  always_comb begin
    dflt_base_nxt = dflt_base_r;
    tok_base_nxt  = tok_base_r;
    at_start_nxt  = at_start_r;
    if (cfg_valid && cfg_ready) begin
      dflt_base_nxt = cfg_data;
    end
    if (accept) begin
      tok_base_nxt = base_now;
      at_start_nxt = in_item.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_base_r <= BASE_DEC;
      tok_base_r  <= '0;
      at_start_r  <= 1'b1;
    end else begin
      dflt_base_r <= dflt_base_nxt;
      tok_base_r  <= tok_base_nxt;
      at_start_r  <= at_start_nxt;
    end
  end

endmodule

// File: hw/rtl/pntp_queue.sv
// Short register queue of classified characters between front and back.
// Uses pntp_pkg for the entry type and depth.
module pntp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pntp_pkg::pntp_entry_t  wdata,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output pntp_pkg::pntp_entry_t  rdata
);
  import pntp_pkg::*;

  pntp_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/pntp_back.sv
// Back end: multiply-accumulate per digit, failure and sign tracking,
// and the output register. Uses pntp_pkg.
module pntp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  pntp_pkg::pntp_entry_t  q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  output pntp_pkg::pntp_out_t    out_item,
  input  logic                   out_stall
);
  import pntp_pkg::*;

  logic [CELL_BITS-1:0] acc_r, acc_nxt;
  logic                 failed_r, failed_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pntp_out_t            out_item_r, out_item_nxt;
  logic [CELL_BITS-1:0] acc_in;
  logic [CELL_BITS-1:0] prod;
  logic [CELL_BITS-1:0] signed_acc;
  logic                 fail_in;
  logic                 out_blocked;

  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;
  assign out_blocked = out_valid_r && out_stall;
  // Hold a final character while the previous result still waits.
  assign q_pop       = !q_empty && !(q_rdata.last && out_blocked);

  always_comb begin
    acc_in     = q_rdata.start ? '0 : acc_r;
    fail_in    = q_rdata.start ? 1'b0 : failed_r;
    neg_nxt    = q_rdata.start ? q_rdata.neg : neg_r;
    failed_nxt = fail_in || (!q_rdata.skip && q_rdata.bad);
    prod       = acc_in * CELL_BITS'(q_rdata.base);
    acc_nxt    = acc_in;
    if (!q_rdata.skip && !failed_nxt) begin
      acc_nxt = prod + CELL_BITS'(q_rdata.digit);
    end
    signed_acc = neg_nxt ? (~acc_nxt + 1'b1) : acc_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && q_rdata.last) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.is_number = !failed_nxt;
      out_item_nxt.value     = failed_nxt ? '0 : VALUE_BITS'(signed_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      failed_r    <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_r    <= acc_nxt;
        failed_r <= failed_nxt;
        neg_r    <= neg_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
